// ----- rtl/ecpr_pkg.sv -----
package ecpr_pkg;

    localparam int NUM_FRAMES = 4;
    localparam int PAGE_BITS  = 16;
    localparam int FRAME_W    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int PASS_W     = 2;

    localparam logic [FRAME_W-1:0] LAST_FRAME = FRAME_W'(NUM_FRAMES - 1);

    typedef logic [PAGE_BITS-1:0] t_page;
    typedef logic [FRAME_W-1:0]   t_frame;

    // one frame table entry; the valid bit lives in flops in the controller
    typedef struct packed {
        t_page page;
        logic  use_b;
        logic  mod;
    } t_entry;

    typedef struct packed {
        logic   we;
        t_frame waddr;
        t_entry wdata;
        t_frame raddr;
    } t_mem_req;

    typedef struct packed {
        logic   hit;
        t_frame frame;
        logic   ev_valid;
        t_page  ev_page;
        logic   ev_dirty;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HIT,
        S_SCAN,
        S_DONE
    } t_state;

    function automatic t_frame next_frame(input t_frame f);
        t_frame nf;
        if (f == LAST_FRAME) begin
            nf = '0;
        end else begin
            nf = f + t_frame'(1);
        end
        return nf;
    endfunction

endpackage

// ----- rtl/enhanced_clock_page_replacement.sv -----
// Timing: a hit returns once the frames from the hand up to the matching one have been
// checked; a fill once every frame has been checked; an eviction after the hit search and
// the victim scan, all paced by one frame table read per cycle.
// Throughput: one request at a time; the next is taken the cycle after the result is
// registered, which may be while that result is still waiting downstream.
// Reset (synchronous, active low): all frames empty, hand at frame zero, no result pending.
module enhanced_clock_page_replacement (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // page_number
    input  logic        s_axis_tuser,   // is_write
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // frame_index[1:0], evicted_valid[2], evicted_page[18:3], evicted_dirty[19], zero
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tuser    // hit
);

    ecpr_pkg::t_mem_req mem_req;
    ecpr_pkg::t_entry   mem_rdata;
    ecpr_pkg::t_result  res;
    logic               res_valid;
    logic               out_free;

    logic        r_m_valid;
    logic [23:0] r_m_data;
    logic        r_m_user;

    assign out_free = !r_m_valid || m_axis_tready;

    ecpr_frame_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    ecpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_page  (ecpr_pkg::PAGE_BITS'(s_axis_tdata)),
        .i_req_wr    (s_axis_tuser),
        .o_req_ready (s_axis_tready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (out_free),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_free) begin
            r_m_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && out_free) begin
            r_m_data <= {4'b0, res.ev_dirty, 16'(res.ev_page), res.ev_valid, 2'(res.frame)};
            r_m_user <= res.hit;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

// ----- rtl/ecpr_frame_mem.sv -----
module ecpr_frame_mem (
    input  logic              i_clk,
    input  ecpr_pkg::t_mem_req i_req,
    output ecpr_pkg::t_entry  o_rdata
);

    ecpr_pkg::t_entry r_mem [ecpr_pkg::NUM_FRAMES];
    ecpr_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ecpr_ctrl.sv -----
module ecpr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  ecpr_pkg::t_page    i_req_page,
    input  logic               i_req_wr,
    output logic               o_req_ready,
    output logic               o_res_valid,
    output ecpr_pkg::t_result  o_res,
    input  logic               i_res_ready,
    output ecpr_pkg::t_mem_req o_mem_req,
    input  ecpr_pkg::t_entry   i_mem_rdata
);

    ecpr_pkg::t_state  r_state;
    ecpr_pkg::t_state  n_state;
    ecpr_pkg::t_page   r_page;
    logic              r_wr;
    ecpr_pkg::t_frame  r_chk;
    ecpr_pkg::t_frame  r_cnt;
    logic [ecpr_pkg::PASS_W-1:0] r_pass;
    ecpr_pkg::t_frame  r_hand;
    logic [ecpr_pkg::NUM_FRAMES-1:0] r_valid;
    logic              r_empty_found;
    ecpr_pkg::t_frame  r_empty;
    ecpr_pkg::t_result r_res;

    logic             accept;
    logic             cur_valid;
    logic             is_hit;
    logic             last;
    logic             have_empty;
    ecpr_pkg::t_frame empty_sel;
    logic             scan_b;
    logic             victim;

    assign accept     = i_req_valid && o_req_ready;
    assign cur_valid  = r_valid[r_chk];
    assign is_hit     = cur_valid && (i_mem_rdata.page == r_page);
    assign last       = (r_cnt == ecpr_pkg::LAST_FRAME);
    assign have_empty = r_empty_found || !cur_valid;
    assign empty_sel  = r_empty_found ? r_empty : r_chk;
    assign scan_b     = r_pass[0];
    assign victim     = !i_mem_rdata.use_b && (i_mem_rdata.mod == scan_b);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ecpr_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = ecpr_pkg::S_HIT;
                end
            end
            ecpr_pkg::S_HIT: begin
                if (is_hit) begin
                    n_state = ecpr_pkg::S_DONE;
                end else if (last) begin
                    n_state = have_empty ? ecpr_pkg::S_DONE : ecpr_pkg::S_SCAN;
                end
            end
            ecpr_pkg::S_SCAN: begin
                if (victim) begin
                    n_state = ecpr_pkg::S_DONE;
                end
            end
            ecpr_pkg::S_DONE: begin
                if (i_res_ready) begin
                    n_state = ecpr_pkg::S_IDLE;
                end
            end
            default: n_state = ecpr_pkg::S_IDLE;
        endcase
    end

    // read of the next frame is always in flight; a spare read on exit is harmless
    always_comb begin
        o_req_ready       = 1'b0;
        o_res_valid       = 1'b0;
        o_mem_req.we      = 1'b0;
        o_mem_req.waddr   = r_chk;
        o_mem_req.wdata   = i_mem_rdata;
        o_mem_req.raddr   = ecpr_pkg::next_frame(r_chk);
        unique case (r_state)
            ecpr_pkg::S_IDLE: begin
                o_req_ready     = 1'b1;
                o_mem_req.raddr = r_hand;
            end
            ecpr_pkg::S_HIT: begin
                if (is_hit) begin
                    o_mem_req.we          = 1'b1;
                    o_mem_req.wdata.use_b = 1'b1;
                    o_mem_req.wdata.mod   = i_mem_rdata.mod || r_wr;
                end else if (last && have_empty) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = empty_sel;
                    o_mem_req.wdata = '{page: r_page, use_b: 1'b1, mod: r_wr};
                end
            end
            ecpr_pkg::S_SCAN: begin
                if (victim) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.wdata = '{page: r_page, use_b: 1'b1, mod: r_wr};
                end else if (scan_b) begin
                    o_mem_req.we          = 1'b1;
                    o_mem_req.wdata.use_b = 1'b0;
                end
            end
            ecpr_pkg::S_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ecpr_pkg::S_IDLE;
            r_hand  <= '0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ecpr_pkg::S_HIT && !is_hit && last && have_empty) begin
                r_valid[empty_sel] <= 1'b1;
                r_hand             <= ecpr_pkg::next_frame(empty_sel);
            end
            if (r_state == ecpr_pkg::S_SCAN && victim) begin
                r_hand <= ecpr_pkg::next_frame(r_chk);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ecpr_pkg::S_IDLE: begin
                r_page        <= i_req_page;
                r_wr          <= i_req_wr;
                r_chk         <= r_hand;
                r_cnt         <= '0;
                r_empty_found <= 1'b0;
            end
            ecpr_pkg::S_HIT: begin
                if (is_hit) begin
                    r_res <= '{hit: 1'b1, frame: r_chk, ev_valid: 1'b0,
                               ev_page: '0, ev_dirty: 1'b0};
                end else if (last) begin
                    r_res <= '{hit: 1'b0, frame: empty_sel, ev_valid: 1'b0,
                               ev_page: '0, ev_dirty: 1'b0};
                    // hit search started at the hand, so the victim scan does too
                    r_chk  <= ecpr_pkg::next_frame(r_chk);
                    r_cnt  <= '0;
                    r_pass <= '0;
                end else begin
                    if (!cur_valid && !r_empty_found) begin
                        r_empty_found <= 1'b1;
                        r_empty       <= r_chk;
                    end
                    r_chk <= ecpr_pkg::next_frame(r_chk);
                    r_cnt <= r_cnt + ecpr_pkg::t_frame'(1);
                end
            end
            ecpr_pkg::S_SCAN: begin
                if (victim) begin
                    r_res <= '{hit: 1'b0, frame: r_chk, ev_valid: 1'b1,
                               ev_page: i_mem_rdata.page, ev_dirty: i_mem_rdata.mod};
                end else begin
                    r_chk <= ecpr_pkg::next_frame(r_chk);
                    if (last) begin
                        r_cnt  <= '0;
                        r_pass <= r_pass + ecpr_pkg::PASS_W'(1);
                    end else begin
                        r_cnt <= r_cnt + ecpr_pkg::t_frame'(1);
                    end
                end
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

// ----- rtl/ecpr_checker.sv -----
module ecpr_assert (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // one request in flight: no back-to-back accepts
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in work");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[2])
        else $error("hit reported with an eviction");

    a_no_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[19:3] == 17'd0)
        else $error("evicted page or dirty set without an eviction");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered after reset");

endmodule

bind enhanced_clock_page_replacement ecpr_assert u_ecpr_assert (.*);

// ----- bench/ecpr_checker.sv -----
module ecpr_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,   // page_number
    input  logic        i_s_tuser,   // is_write
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // frame_index[1:0], evicted_valid[2], evicted_page[18:3], evicted_dirty[19], zero
    input  logic [23:0] i_m_tdata,
    input  logic        i_m_tuser,   // hit
    output int          o_mismatches,
    output int          o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    // shadow frame table
    ecpr_pkg::t_page  page_at [ecpr_pkg::NUM_FRAMES];
    logic             held    [ecpr_pkg::NUM_FRAMES];
    logic             used    [ecpr_pkg::NUM_FRAMES];
    logic             dirty   [ecpr_pkg::NUM_FRAMES];
    ecpr_pkg::t_frame hand;

    ecpr_pkg::t_result outcomes[$];

    initial o_mismatches = 0;
    initial o_pending = 0;

    function automatic ecpr_pkg::t_frame step_frame(input ecpr_pkg::t_frame f);
        return (f == ecpr_pkg::t_frame'(ecpr_pkg::NUM_FRAMES - 1)) ?
            ecpr_pkg::t_frame'(0) : f + ecpr_pkg::t_frame'(1);
    endfunction

    function automatic void load_frame(input ecpr_pkg::t_frame f,
                                       input ecpr_pkg::t_page pg, input logic wr);
        page_at[f] = pg;
        held[f]    = 1'b1;
        used[f]    = 1'b1;
        dirty[f]   = wr;
        hand       = step_frame(f);
    endfunction

    function automatic ecpr_pkg::t_result resolve_reference(input ecpr_pkg::t_page pg,
                                                            input logic wr);
        ecpr_pkg::t_result r;
        ecpr_pkg::t_frame  f;
        bit                found;
        bit                scan_b;
        r = '0;
        for (int i = 0; i < ecpr_pkg::NUM_FRAMES; i++) begin
            if (held[i] && page_at[i] == pg) begin
                used[i] = 1'b1;
                if (wr) begin
                    dirty[i] = 1'b1;
                end
                r.hit   = 1'b1;
                r.frame = ecpr_pkg::t_frame'(i);
                return r;
            end
        end
        f = hand;
        for (int i = 0; i < ecpr_pkg::NUM_FRAMES; i++) begin
            if (!held[f]) begin
                load_frame(f, pg, wr);
                r.frame = f;
                return r;
            end
            f = step_frame(f);
        end
        // clean-and-unused passes alternate with dirty-and-unused passes that clear use bits as they go
        f = hand;
        found = 1'b0;
        for (int pass = 0; pass < 4 && !found; pass++) begin
            scan_b = ((pass % 2) == 1);
            for (int i = 0; i < ecpr_pkg::NUM_FRAMES && !found; i++) begin
                if (!used[f] && dirty[f] == scan_b) begin
                    found = 1'b1;
                end else begin
                    if (scan_b) begin
                        used[f] = 1'b0;
                    end
                    f = step_frame(f);
                end
            end
        end
        if (!found) begin
            f = hand;
        end
        r.ev_valid = 1'b1;
        r.ev_page  = page_at[f];
        r.ev_dirty = dirty[f];
        load_frame(f, pg, wr);
        r.frame = f;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        if (o_mismatches < MAX_REPORTS) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
        end
        o_mismatches = o_mismatches + 1;
    endtask

    always @(posedge i_clk) begin
        ecpr_pkg::t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < ecpr_pkg::NUM_FRAMES; i++) begin
                page_at[i] = '0;
                held[i]    = 1'b0;
                used[i]    = 1'b0;
                dirty[i]   = 1'b0;
            end
            hand = '0;
            outcomes.delete();
            o_pending <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (outcomes.size() == 0) begin
                    note_mismatch("unrequested result", 0, i_m_tdata);
                end else begin
                    want = outcomes.pop_front();
                    if (i_m_tuser !== want.hit)
                        note_mismatch("hit", want.hit, i_m_tuser);
                    if (i_m_tdata[1:0] !== want.frame)
                        note_mismatch("frame_index", want.frame, i_m_tdata[1:0]);
                    if (i_m_tdata[2] !== want.ev_valid)
                        note_mismatch("evicted_valid", want.ev_valid, i_m_tdata[2]);
                    if (i_m_tdata[18:3] !== want.ev_page)
                        note_mismatch("evicted_page", want.ev_page, i_m_tdata[18:3]);
                    if (i_m_tdata[19] !== want.ev_dirty)
                        note_mismatch("evicted_dirty", want.ev_dirty, i_m_tdata[19]);
                    if (i_m_tdata[23:20] !== 4'b0)
                        note_mismatch("tdata padding", 0, i_m_tdata[23:20]);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                outcomes.push_back(resolve_reference(i_s_tdata, i_s_tuser));
            end
            o_pending <= outcomes.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_REFS  = 1250;
    localparam int POOL_MAX     = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // page_number
    logic        s_axis_tuser = 1'b0; // is_write
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // frame_index[1:0], evicted_valid[2], evicted_page[18:3], evicted_dirty[19], zero
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;        // hit

    int mismatches;
    int outstanding;
    int cycles = 0;
    bit steady_tx = 1'b0;

    always #2 i_clk = ~i_clk;

    enhanced_clock_page_replacement DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    ecpr_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_mismatches (mismatches),
        .o_pending    (outstanding)
    );

    // mostly short gaps, the odd long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic offer_reference(input ecpr_pkg::t_page pg, input logic wr);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pg;
        s_axis_tuser  <= wr;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        gap = steady_tx ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("enhanced_clock_page_replacement test failed");
            $finish;
        end
    end

    // downstream back-pressure
    initial begin
        int stall;
        @(posedge i_clk);
        forever begin
            stall = ($urandom_range(0, 24) == 0) ? 0 : pick_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat (($urandom_range(0, 24) == 0) ? 200 : $urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    initial begin
        ecpr_pkg::t_page pool [POOL_MAX];
        int              pool_n;
        int              write_bias;
        int              r;
        ecpr_pkg::t_page pg;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // page 0 must miss: empty frames are not valid, whatever page they hold
        offer_reference(16'h0000, 1'b0);
        offer_reference(16'hFFFF, 1'b1);
        offer_reference(16'h8000, 1'b0);
        offer_reference(16'h0001, 1'b0);
        offer_reference(16'hFFFF, 1'b0);
        offer_reference(16'h0001, 1'b1);
        offer_reference(16'h0000, 1'b1);
        // table full, every use bit set: scans must wrap and clear
        offer_reference(16'h5555, 1'b0);
        offer_reference(16'hAAAA, 1'b1);
        offer_reference(16'hFFFF, 1'b0);
        offer_reference(16'h1234, 1'b1);
        offer_reference(16'h5555, 1'b1);
        offer_reference(16'hFFFF, 1'b1);
        offer_reference(16'h0000, 1'b0);
        offer_reference(16'hAAAA, 1'b0);
        offer_reference(16'h7FFF, 1'b0);
        offer_reference(16'h0002, 1'b1);
        offer_reference(16'h0003, 1'b1);
        offer_reference(16'h0004, 1'b1);
        offer_reference(16'h0005, 1'b0);
        offer_reference(16'h0002, 1'b0);
        offer_reference(16'h0006, 1'b0);
        hold_until_drained();

        pool_n = 4;
        write_bias = 50;
        for (int k = 0; k < POOL_MAX; k++) begin
            pool[k] = ecpr_pkg::t_page'($urandom());
        end
        for (int n = 0; n < RANDOM_REFS; n++) begin
            if (n % 100 == 0) begin
                steady_tx  = ($urandom_range(0, 3) == 0);
                pool_n     = $urandom_range(4, POOL_MAX);
                write_bias = $urandom_range(0, 100);
                for (int k = 0; k < POOL_MAX; k++) begin
                    if ($urandom_range(0, 2) == 0) begin
                        pool[k] = ecpr_pkg::t_page'($urandom());
                    end
                end
            end
            if (n == RANDOM_REFS / 2) begin
                hold_until_drained();
            end
            r = $urandom_range(0, 99);
            if (r < 10) begin
                pg = ecpr_pkg::t_page'($urandom());
            end else if (r < 14) begin
                pg = ecpr_pkg::t_page'($urandom());
                pool[$urandom_range(0, pool_n - 1)] = pg;
            end else begin
                pg = pool[$urandom_range(0, pool_n - 1)];
            end
            offer_reference(pg, ($urandom_range(0, 99) < write_bias));
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("enhanced_clock_page_replacement test passed");
        end else begin
            $display("enhanced_clock_page_replacement test failed");
        end
        $finish;
    end

endmodule
